// File: rtl/map_point_store_defines.svh
`ifndef MAP_POINT_STORE_DEFINES_SVH
`define MAP_POINT_STORE_DEFINES_SVH

// Plain property, checked on every clock edge out of reset
`define MPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define MPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mps_pkg.sv
package mps_pkg;

    localparam int ENTRIES    = 1024;
    localparam int ADDR_W     = $clog2(ENTRIES);
    localparam int MARK_W     = ADDR_W + 1;
    localparam int POS_W      = 24;
    localparam int CONF_W     = 16;
    localparam int SEEN_W     = 32;
    localparam int RAD_W      = 48;
    localparam int SLOT_W     = 10;
    localparam int HW_W       = 11;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int PROD_W     = 2 * CONF_W;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEEP      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CONF = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [CONF_W-1:0] RST_DECAY     = CONF_W'(62259);
    localparam logic [CONF_W-1:0] RST_KEEP      = CONF_W'(3277);
    localparam logic [RAD_W-1:0]  RST_RADIUS    = RAD_W'(16777);
    localparam logic [CONF_W-1:0] RST_INIT_CONF = CONF_W'(58982);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SCAN,
        S_PLACE,
        S_READ
    } t_state;

    typedef struct packed {
        t_cmd                     cmd;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic [SLOT_W-1:0]        read_slot;
    } t_item;

    typedef struct packed {
        logic                     active;
        logic [CONF_W-1:0]        conf;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic [SEEN_W-1:0]        seen;
    } t_entry;

    typedef struct packed {
        logic [CONF_W-1:0] decay;
        logic [CONF_W-1:0] keep;
        logic [RAD_W-1:0]  radius;
        logic [CONF_W-1:0] init_conf;
    } t_cfg;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic                     active;
        logic [CONF_W-1:0]        conf;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic [SEEN_W-1:0]        seen;
        logic [HW_W-1:0]          high_water;
    } t_result;

endpackage

// File: rtl/mps_ifs.sv
interface mps_in_if;
    import mps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [SLOT_W-1:0]       read_slot;

    modport source (output valid, command, pos_x, pos_y, pos_z, read_slot, input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, read_slot, output ready);
endinterface

interface mps_out_if;
    import mps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [SLOT_W-1:0]       slot;
    logic                    entry_active;
    logic [CONF_W-1:0]       entry_confidence;
    logic signed [POS_W-1:0] entry_x;
    logic signed [POS_W-1:0] entry_y;
    logic signed [POS_W-1:0] entry_z;
    logic [SEEN_W-1:0]       entry_last_seen;
    logic [HW_W-1:0]         high_water;

    modport source (output valid, status, slot, entry_active, entry_confidence, entry_x,
                    entry_y, entry_z, entry_last_seen, high_water, input ready);
    modport sink   (input valid, status, slot, entry_active, entry_confidence, entry_x,
                    entry_y, entry_z, entry_last_seen, high_water, output ready);
endinterface

interface mps_cfg_if;
    import mps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mps_ram.sv
module mps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/mps_front.sv
`include "map_point_store_defines.svh"

module mps_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mps_in_if.sink         i_in,
    output mps_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_ready
);
    import mps_pkg::*;

    t_item              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               push;
    logic               pop;
    t_item              in_item;

    // Classify the incoming word
    always_comb begin
        in_item.cmd       = t_cmd'(i_in.command);
        in_item.x         = i_in.pos_x;
        in_item.y         = i_in.pos_y;
        in_item.z         = i_in.pos_z;
        in_item.read_slot = i_in.read_slot;
    end

    assign i_in.ready   = (r_cnt != (Q_PTR_W + 1)'(Q_DEPTH));
    assign push         = i_in.valid && i_in.ready;
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];
    assign pop          = o_item_valid && i_item_ready;

    // Queue words towards the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= in_item;
                r_wp      <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `MPS_ASSERT(a_q_bound, r_cnt <= (Q_PTR_W + 1)'(Q_DEPTH), "queue count overflow")
    `MPS_ASSERT_NEXT(a_q_up, push && !pop, r_cnt == $past(r_cnt) + 1'b1, "queue did not grow")
    `MPS_ASSERT_NEXT(a_q_down, pop && !push, r_cnt == $past(r_cnt) - 1'b1, "queue did not shrink")
endmodule

// File: rtl/mps_back.sv
`include "map_point_store_defines.svh"

module mps_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mps_pkg::t_item i_item,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  mps_pkg::t_cfg  i_cfg,
    mps_out_if.source      o_out
);
    import mps_pkg::*;

    t_state                   r_state;
    t_state                   n_state;
    t_item                    r_item;
    logic [MARK_W-1:0]        r_idx;
    logic [MARK_W-1:0]        r_used;
    logic [SEEN_W-1:0]        r_frame;
    logic                     r_p1_vld;
    logic [ADDR_W-1:0]        r_p1_addr;
    logic                     r_p2_vld;
    logic [SQ_W-1:0]          r_sq_x;
    logic [SQ_W-1:0]          r_sq_y;
    logic [SQ_W-1:0]          r_sq_z;
    logic                     r_dup;
    logic                     r_free_found;
    logic [ADDR_W-1:0]        r_free_slot;
    logic                     r_out_valid;
    t_result                  r_res;

    logic                     start;
    logic                     issuing;
    logic                     tick_done;
    logic                     scan_done;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [$bits(t_entry)-1:0] rd_raw;
    t_entry                   rd_entry;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    t_entry                   wr_data;
    logic [PROD_W-1:0]        prod;
    logic [CONF_W-1:0]        conf_dec;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
    logic signed [SQ_W-1:0]   sq_x;
    logic signed [SQ_W-1:0]   sq_y;
    logic signed [SQ_W-1:0]   sq_z;
    logic [SUM_W-1:0]         sum_sq;
    logic                     hit;
    logic                     place_ok;
    logic                     place_new;
    logic [ADDR_W-1:0]        place_slot;

    // Result word with no entry data
    function automatic t_result short_result(t_status st, logic [SLOT_W-1:0] sl,
                                             logic [HW_W-1:0] hw);
        t_result r;
        r            = '0;
        r.status     = st;
        r.slot       = sl;
        r.high_water = hw;
        return r;
    endfunction

    mps_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    assign rd_entry = t_entry'(rd_raw);

    // Walk control: entries at or above the used mark are not walked
    assign start     = (r_state == S_IDLE) && i_item_valid && !r_out_valid;
    assign issuing   = ((r_state == S_TICK) || (r_state == S_SCAN)) && (r_idx < r_used);
    assign tick_done = !issuing && !r_p1_vld;
    assign scan_done = !issuing && !r_p1_vld && !r_p2_vld;

    // Decay one confidence
    assign prod     = PROD_W'(rd_entry.conf) * PROD_W'(i_cfg.decay);
    assign conf_dec = prod[PROD_W-1 -: CONF_W];

    // Squared distance, squares registered before the sum
    assign dx     = {rd_entry.x[POS_W-1], rd_entry.x} - {r_item.x[POS_W-1], r_item.x};
    assign dy     = {rd_entry.y[POS_W-1], rd_entry.y} - {r_item.y[POS_W-1], r_item.y};
    assign dz     = {rd_entry.z[POS_W-1], rd_entry.z} - {r_item.z[POS_W-1], r_item.z};
    assign sq_x   = dx * dx;
    assign sq_y   = dy * dy;
    assign sq_z   = dz * dz;
    assign sum_sq = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);
    assign hit    = r_p2_vld && (sum_sq < SUM_W'(i_cfg.radius));

    // Pick the slot for a new point
    assign place_new  = !r_free_found && (r_used < MARK_W'(ENTRIES));
    assign place_ok   = !r_dup && (r_free_found || place_new);
    assign place_slot = r_free_found ? r_free_slot : r_used[ADDR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_item.cmd)
                        CMD_TICK:   n_state = S_TICK;
                        CMD_INSERT: n_state = S_SCAN;
                        CMD_READ:   n_state = S_READ;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK:  if (tick_done) n_state = S_IDLE;
            S_SCAN:  if (scan_done) n_state = S_PLACE;
            S_PLACE: n_state = S_IDLE;
            S_READ:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory ports and queue pop
    always_comb begin
        o_item_ready = start;
        rd_en        = 1'b0;
        rd_addr      = r_idx[ADDR_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_p1_addr;
        wr_data      = rd_entry;
        case (r_state)
            S_IDLE: begin
                if (start && (i_item.cmd == CMD_READ)) begin
                    rd_en   = 1'b1;
                    rd_addr = i_item.read_slot[ADDR_W-1:0];
                end
            end
            S_TICK: begin
                rd_en = issuing;
                if (r_p1_vld && rd_entry.active) begin
                    wr_en          = 1'b1;
                    wr_data.conf   = conf_dec;
                    wr_data.active = (conf_dec >= i_cfg.keep);
                end
            end
            S_SCAN: begin
                rd_en = issuing;
            end
            S_PLACE: begin
                wr_en          = place_ok;
                wr_addr        = place_slot;
                wr_data.active = 1'b1;
                wr_data.conf   = i_cfg.init_conf;
                wr_data.x      = r_item.x;
                wr_data.y      = r_item.y;
                wr_data.z      = r_item.z;
                wr_data.seen   = r_frame;
            end
            default: ;
        endcase
    end

    // Sequencer registers and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_used       <= '0;
            r_frame      <= '0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_dup        <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // Advance the walk pipeline
            r_p1_vld  <= issuing;
            r_p1_addr <= r_idx[ADDR_W-1:0];
            r_p2_vld  <= (r_state == S_SCAN) && r_p1_vld && rd_entry.active;
            r_sq_x    <= sq_x;
            r_sq_y    <= sq_y;
            r_sq_z    <= sq_z;
            if (issuing) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit) begin
                r_dup <= 1'b1;
            end
            if ((r_state == S_SCAN) && r_p1_vld && !rd_entry.active && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_p1_addr;
            end

            // Take a new word
            if (start) begin
                r_item       <= i_item;
                r_idx        <= '0;
                r_dup        <= 1'b0;
                r_free_found <= 1'b0;
                if (i_item.cmd == CMD_TICK) begin
                    r_frame <= r_frame + 1'b1;
                end
                if (i_item.cmd == CMD_NOP) begin
                    r_res       <= short_result(ST_DONE, '0, HW_W'(r_used));
                    r_out_valid <= 1'b1;
                end
            end

            // Finish a tick
            if ((r_state == S_TICK) && tick_done) begin
                r_res       <= short_result(ST_DONE, '0, HW_W'(r_used));
                r_out_valid <= 1'b1;
            end

            // Finish an insert
            if (r_state == S_PLACE) begin
                r_res <= short_result(r_dup ? ST_DUPLICATE : (place_ok ? ST_INSERTED : ST_FULL),
                                      place_ok ? SLOT_W'(place_slot) : '0,
                                      (place_ok && place_new) ? HW_W'(r_used + 1'b1)
                                                              : HW_W'(r_used));
                if (place_ok && place_new) begin
                    r_used <= r_used + 1'b1;
                end
                r_out_valid <= 1'b1;
            end

            // Finish a read
            if (r_state == S_READ) begin
                r_res.status     <= ST_DONE;
                r_res.slot       <= r_item.read_slot;
                r_res.active     <= rd_entry.active && (MARK_W'(r_item.read_slot) < r_used);
                r_res.conf       <= rd_entry.conf;
                r_res.x          <= rd_entry.x;
                r_res.y          <= rd_entry.y;
                r_res.z          <= rd_entry.z;
                r_res.seen       <= rd_entry.seen;
                r_res.high_water <= HW_W'(r_used);
                r_out_valid      <= 1'b1;
            end
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_res.status;
    assign o_out.slot             = r_res.slot;
    assign o_out.entry_active     = r_res.active;
    assign o_out.entry_confidence = r_res.conf;
    assign o_out.entry_x          = r_res.x;
    assign o_out.entry_y          = r_res.y;
    assign o_out.entry_z          = r_res.z;
    assign o_out.entry_last_seen  = r_res.seen;
    assign o_out.high_water       = r_res.high_water;

    `MPS_ASSERT(a_used_bound, r_used <= MARK_W'(ENTRIES), "used mark beyond table")
    `MPS_ASSERT_IMPL(a_free_below, r_free_found, MARK_W'(r_free_slot) < r_used, "free slot above mark")
    `MPS_ASSERT_IMPL(a_busy_empty, r_state != S_IDLE, !r_out_valid, "result held while busy")
endmodule

// File: rtl/map_point_store.sv
// Read: the result is registered from the entry memory's read data; a no-op gives a done result.
// Tick and insert walk the entries below the used mark, one table entry per cycle
// through the single read port of the entry memory.
// Throughput: one word in the back end at a time; a two-word queue takes input meanwhile.
// Reset (synchronous, active low) clears the used mark, frame count and registers;
// entries above the used mark read as inactive, so no clearing pass is needed.
module map_point_store (
    input  logic i_clk,
    input  logic i_rst_n,
    mps_in_if.sink     i_in,
    mps_out_if.source  o_out,
    mps_cfg_if.sink    i_cfg
);
    import mps_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    logic  q_valid;
    logic  q_ready;

    assign i_cfg.ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay     <= RST_DECAY;
            r_cfg.keep      <= RST_KEEP;
            r_cfg.radius    <= RST_RADIUS;
            r_cfg.init_conf <= RST_INIT_CONF;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_DECAY:     r_cfg.decay     <= i_cfg.data[CONF_W-1:0];
                REG_KEEP:      r_cfg.keep      <= i_cfg.data[CONF_W-1:0];
                REG_RADIUS:    r_cfg.radius    <= i_cfg.data[RAD_W-1:0];
                REG_INIT_CONF: r_cfg.init_conf <= i_cfg.data[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    mps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (q_item),
        .o_item_valid (q_valid),
        .i_item_ready (q_ready)
    );

    mps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_cfg        (r_cfg),
        .o_out        (o_out)
    );
endmodule
